>>> hdl/utf8v_pkg.sv
// shared types, constants and codes of the utf-8 text validator
package utf8v_pkg;

    // length limit and the width that holds it plus one
    localparam int MAX_TEXT_BYTES = 1024;
    localparam int COUNT_W        = $clog2(MAX_TEXT_BYTES + 2);

    // register file: one 32-bit register, byte address 4*index
    localparam int MAX_BYTES_W = 11;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RESET = 11'd1024;

    typedef enum logic [APB_ADDR_W-3:0] {
        REG_MAX_BYTES = 1'b0
    } reg_index_e;

    typedef enum logic [2:0] {
        FAULT_NONE        = 3'd0,
        FAULT_EMPTY       = 3'd1,
        FAULT_LONG        = 3'd2,
        FAULT_LEAD_SPACE  = 3'd3,
        FAULT_TRAIL_SPACE = 3'd4,
        FAULT_CONTROL     = 3'd5,
        FAULT_MALFORMED   = 3'd6,
        FAULT_CODEPOINT   = 3'd7
    } fault_e;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
        logic       empty_text;
    } utf8v_in_t;

    typedef struct packed {
        logic       text_valid;
        logic [2:0] fault_code;
    } utf8v_out_t;

    // what the scanner reports for the item at the head of the input stage
    typedef struct packed {
        logic       ends;
        utf8v_out_t verdict;
    } utf8v_step_t;

endpackage

>>> hdl/utf8_text_validator_core.sv
// top level of the streaming utf-8 text validator
//
//  channel  | ports                    | moves
//  ---------+--------------------------+------------------------------------------
//  input    | s_valid s_ready s_data   | one text byte per transfer, end/empty marks
//  result   | m_valid m_ready m_data   | one verdict per string
//  config   | psel penable pwrite ...  | max_bytes at byte address 0
//
// one byte per cycle sustained while the result register takes each verdict; a
// verdict passes the input register, then the result register, before it shows
// on m_valid, and it waits in the input register while the result register is stalled;
// the per-string state loop closes through the scan state register
// reset (aresetn low at a clock edge) clears all scan state and both
// stage valids and loads max_bytes with 1024
// a stalled result register holds the verdict and stops only items that end
// a string; bytes in the middle of a string keep flowing
module utf8_text_validator_core
    import utf8v_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  utf8v_in_t             s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output utf8v_out_t            m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // input stage
    logic        in_valid_reg;
    logic        in_valid_next;
    utf8v_in_t   in_data_reg;
    // result stage
    logic        m_valid_reg;
    logic        m_valid_next;
    utf8v_out_t  m_data_reg;

    logic               result_free;
    logic               advance;
    logic [COUNT_W-1:0] limit;
    utf8v_step_t        step_out;

    utf8v_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (limit)
    );

    utf8v_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .item     (in_data_reg),
        .limit    (limit),
        .step_out (step_out)
    );

    // result register can take a verdict this cycle
    assign result_free = !m_valid_reg || m_ready;

    // the head byte is consumed unless it ends a string and the verdict has nowhere to go
    assign advance = in_valid_reg && (!step_out.ends || result_free);

    // input stage refills as it drains
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance && step_out.ends) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && step_out.ends) begin
            m_data_reg <= step_out.verdict;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a shown verdict is consistent with its code
    a_valid_matches_code: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.text_valid == (m_data_reg.fault_code == FAULT_NONE))
    ) else $error("text_valid disagrees with fault_code");

    // back pressure on the input only when the head item is held
    a_stall_has_item: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && step_out.ends && m_valid_reg && !m_ready)
    ) else $error("input stalled without a blocked verdict");

    // a finished string always reaches the result register
    a_verdict_loaded: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (advance && step_out.ends) |=> m_valid_reg
    ) else $error("verdict lost");

    // a middle byte never waits on the result side
    a_middle_flows: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step_out.ends) |-> advance
    ) else $error("middle byte stalled");

endmodule

>>> hdl/utf8v_apb_regs.sv
// apb register file holding the byte limit
module utf8v_apb_regs
    import utf8v_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [COUNT_W-1:0]    limit
);

    logic [MAX_BYTES_W-1:0] max_bytes_reg;
    logic [MAX_BYTES_W-1:0] max_bytes_next;
    logic                   hit;

    assign hit = (paddr[APB_ADDR_W-1:2] == REG_MAX_BYTES);

    always_comb begin
        max_bytes_next = max_bytes_reg;
        if (psel && penable && pwrite && hit) begin
            max_bytes_next = pwdata[MAX_BYTES_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end else begin
            max_bytes_reg <= max_bytes_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata = APB_DATA_W'(max_bytes_reg);
        end
    end

    assign pready = 1'b1;

    // limit in use, clipped to the built-in maximum
    always_comb begin
        if (32'(max_bytes_reg) > 32'(MAX_TEXT_BYTES)) begin
            limit = COUNT_W'(MAX_TEXT_BYTES);
        end else begin
            limit = COUNT_W'(max_bytes_reg);
        end
    end

endmodule

>>> hdl/utf8v_scan.sv
// per-string scan state and single-byte decode step
module utf8v_scan
    import utf8v_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  utf8v_in_t          item,
    input  logic [COUNT_W-1:0] limit,
    output utf8v_step_t        step_out
);

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [1:0]         pending;
        logic [2:0]         seq_len;
        logic [20:0]        acc;
        fault_e             fault;
        logic               lead_space;
        logic               prev_space;
    } scan_state_t;

    scan_state_t st_reg;
    scan_state_t st_next;
    scan_state_t upd;
    scan_state_t post;
    logic [7:0]  b;
    logic [20:0] acc_shift;
    logic        is_space;
    fault_e      code;

    function automatic logic cp_bad(input logic [2:0] len, input logic [20:0] cp);
        logic bad;
        bad = 1'b0;
        if (len == 3'd2 && cp < 21'h80)    bad = 1'b1;
        if (len == 3'd3 && cp < 21'h800)   bad = 1'b1;
        if (len == 3'd4 && cp < 21'h10000) bad = 1'b1;
        if (cp > 21'h10ffff)               bad = 1'b1;
        if (cp >= 21'hd800 && cp <= 21'hdfff) bad = 1'b1;
        if (cp >= 21'h80 && cp <= 21'h9f)  bad = 1'b1;
        return bad;
    endfunction

    assign b         = item.text_byte;
    assign is_space  = (b == 8'h20);
    assign acc_shift = {st_reg.acc[14:0], b[5:0]};

    always_comb begin
        upd = st_reg;
        if (st_reg.count == '0) begin
            upd.lead_space = is_space;
        end
        // saturate one past the limit
        if (st_reg.count <= limit) begin
            upd.count = st_reg.count + 1'b1;
        end
        upd.prev_space = is_space;
        if (st_reg.fault == FAULT_NONE) begin
            if (st_reg.pending == 2'd0) begin
                priority if (b < 8'h80) begin
                    if (b < 8'h20 || b == 8'h7f) begin
                        upd.fault = FAULT_CONTROL;
                    end
                end else if ((b & 8'he0) == 8'hc0) begin
                    upd.seq_len = 3'd2;
                    upd.pending = 2'd1;
                    upd.acc     = 21'(b & 8'h1f);
                end else if ((b & 8'hf0) == 8'he0) begin
                    upd.seq_len = 3'd3;
                    upd.pending = 2'd2;
                    upd.acc     = 21'(b & 8'h0f);
                end else if ((b & 8'hf8) == 8'hf0) begin
                    upd.seq_len = 3'd4;
                    upd.pending = 2'd3;
                    upd.acc     = 21'(b & 8'h07);
                end else begin
                    upd.fault = FAULT_MALFORMED;
                end
            end else if ((b & 8'hc0) != 8'h80) begin
                // broken sequence, byte is not retried as a lead
                upd.fault   = FAULT_MALFORMED;
                upd.pending = 2'd0;
                upd.seq_len = 3'd0;
            end else begin
                upd.acc     = acc_shift;
                upd.pending = st_reg.pending - 2'd1;
                if (st_reg.pending == 2'd1) begin
                    if (cp_bad(st_reg.seq_len, acc_shift)) begin
                        upd.fault = FAULT_CODEPOINT;
                    end
                    upd.seq_len = 3'd0;
                end
            end
        end
    end

    // empty mark adds no byte
    assign post = item.empty_text ? st_reg : upd;

    always_comb begin
        priority if (post.count == '0) begin
            code = FAULT_EMPTY;
        end else if (post.count > limit) begin
            code = FAULT_LONG;
        end else if (post.lead_space) begin
            code = FAULT_LEAD_SPACE;
        end else if (post.prev_space) begin
            code = FAULT_TRAIL_SPACE;
        end else if (post.fault != FAULT_NONE) begin
            code = post.fault;
        end else if (post.pending != 2'd0) begin
            code = FAULT_MALFORMED;
        end else begin
            code = FAULT_NONE;
        end
    end

    assign step_out.ends               = item.empty_text || item.end_of_text;
    assign step_out.verdict.text_valid = (code == FAULT_NONE);
    assign step_out.verdict.fault_code = code;

    always_comb begin
        st_next = st_reg;
        if (step_en) begin
            st_next = step_out.ends ? scan_state_t'('0) : post;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else begin
            st_reg <= st_next;
        end
    end

endmodule
